FILE: sv/mats_pkg.sv
// ----------------------------------------------------------------------------
// mats_pkg: shared definitions for the moving average trend signal block
// Field widths, register indexes, opcodes, signal codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mats_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WINDOW = 128;
  localparam int DEF_PRICE_BITS = 32;

  // Fixed field widths.
  localparam int WLEN_W   = 7;
  localparam int THR_W    = 13;
  localparam int FRAC_W   = 16;
  localparam int PORT_P_W = 32;
  localparam int SIG_W    = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Reset values of the configuration registers.
  localparam logic [WLEN_W-1:0] RST_WINDOW_LENGTH   = 7'd20;
  localparam logic [THR_W-1:0]  RST_TREND_THRESHOLD = 13'd1311;

  // Register indexes, taken from paddr[2].
  localparam logic REG_WINDOW_LENGTH   = 1'b0;
  localparam logic REG_TREND_THRESHOLD = 1'b1;

  // Opcodes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Signal codes.
  localparam logic [SIG_W-1:0] SIG_HOLD = 2'd0;
  localparam logic [SIG_W-1:0] SIG_BUY  = 2'd1;
  localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

  // Depth of the result queue.
  localparam int OUT_DEPTH = 4;

endpackage

`default_nettype wire

FILE: sv/moving_average_trend_signal.sv
// ----------------------------------------------------------------------------
// moving_average_trend_signal: sliding window mean and trend signal
// Keeps the last window_length prices in a ring memory with a running sum and
// signals buy, sell or hold on an evaluate transaction.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while not stalled, push or
// evaluate, in any mix. A push writes the price into the ring memory and
// reads the entry that leaves the window in the same cycle; the running sum
// is updated in the following cycle from the registered read data. An
// evaluate passes the memory read stage and a two-stage compare (multiply,
// then a wide compare) before its result is written into the queue. Results
// wait in a four-entry queue, so input is stalled only when four evaluate
// results are outstanding. Writing window_length clears the window;
// trend_threshold takes effect at once.
`default_nettype none

module moving_average_trend_signal #(
  parameter int MAX_WINDOW = mats_pkg::DEF_MAX_WINDOW,
  parameter int PRICE_BITS = mats_pkg::DEF_PRICE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input transactions
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [mats_pkg::PORT_P_W-1:0]  price_i,
  // result transactions
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mats_pkg::SIG_W-1:0]     signal_o,
  output logic [mats_pkg::PORT_P_W-1:0]  order_price_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mats_pkg::PADDR_W-1:0]   paddr,
  input  logic [mats_pkg::PDATA_W-1:0]   pwdata,
  output logic [mats_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import mats_pkg::*;

  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int SUM_W  = PRICE_BITS + AW;
  localparam int MPR_W  = SUM_W + THR_W;
  localparam int CMP_W  = SUM_W + FRAC_W;
  localparam int OW     = ((AW + 1) > WLEN_W ? (AW + 1) : WLEN_W) + 1;
  localparam int QA_W   = $clog2(OUT_DEPTH);
  localparam int QC_W   = $clog2(OUT_DEPTH + 1);

  // ---------------- configuration ----------------
  logic [WLEN_W-1:0] cfg_len_q;
  logic [THR_W-1:0]  cfg_thr_q;
  logic              cfg_we;
  logic              len_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign len_we = cfg_we && (paddr[2] == REG_WINDOW_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= RST_WINDOW_LENGTH;
      cfg_thr_q <= RST_TREND_THRESHOLD;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_WINDOW_LENGTH:   cfg_len_q <= pwdata[WLEN_W-1:0];
        REG_TREND_THRESHOLD: cfg_thr_q <= pwdata[THR_W-1:0];
        default:             cfg_len_q <= cfg_len_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_WINDOW_LENGTH:   prdata = PDATA_W'(cfg_len_q);
      REG_TREND_THRESHOLD: prdata = PDATA_W'(cfg_thr_q);
      default:             prdata = '0;
    endcase
  end

  // Effective window length saturates at the ring depth.
  logic [WLEN_W-1:0] eff_len;
  assign eff_len = (32'(cfg_len_q) > MAX_WINDOW) ? WLEN_W'(MAX_WINDOW) : cfg_len_q;

  // ---------------- stage 0: accept, ring write and read ----------------
  logic                  in_acc;
  logic                  push_en;
  logic                  eval_acc;
  logic                  full;
  logic [PRICE_BITS-1:0] price_in;
  logic [PRICE_BITS+PORT_P_W-1:0] price_ext;
  logic [OW-1:0]         old_diff;
  logic [AW-1:0]         old_addr;

  logic [AW-1:0]         wp_q, wp_d;
  logic [WLEN_W-1:0]     fill_q, fill_d;
  logic [PRICE_BITS-1:0] newest_q, newest_d;

  logic [PRICE_BITS-1:0] ring [MAX_WINDOW];
  logic [PRICE_BITS-1:0] rd_q;

  logic [QC_W-1:0]       pend_q;

  assign in_stall_o = (pend_q == QC_W'(OUT_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign push_en    = in_acc && (opcode_i == OP_PUSH) && (eff_len != '0);
  assign eval_acc   = in_acc && (opcode_i == OP_EVAL);
  assign full       = (fill_q >= eff_len);

  assign price_ext = {{PRICE_BITS{1'b0}}, price_i};
  assign price_in  = price_ext[PRICE_BITS-1:0];

  // Entry that leaves the window: write pointer minus length, modulo the depth.
  always_comb begin
    old_diff = OW'(wp_q) - OW'(eff_len);
    if (old_diff[OW-1]) begin
      old_addr = AW'(old_diff + OW'(MAX_WINDOW));
    end else begin
      old_addr = AW'(old_diff);
    end
  end

  always_comb begin
    wp_d     = wp_q;
    fill_d   = fill_q;
    newest_d = newest_q;
    if (len_we) begin
      wp_d     = '0;
      fill_d   = '0;
      newest_d = '0;
    end else if (push_en) begin
      wp_d     = (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
      newest_d = price_in;
      if (!full) begin
        fill_d = fill_q + WLEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      fill_q   <= '0;
      newest_q <= '0;
    end else begin
      wp_q     <= wp_d;
      fill_q   <= fill_d;
      newest_q <= newest_d;
    end
  end

  // Read-first ring memory: with a full-depth window the leaving entry is
  // the one being overwritten, and the old value is what is returned.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      ring[wp_q] <= price_in;
    end
    rd_q <= ring[old_addr];
  end

  // Stage 1 registers.
  logic                  s1_push_q, s1_eval_q;
  logic                  s1_sub_q, s1_elig_q;
  logic [PRICE_BITS-1:0] s1_price_q, s1_newest_q;
  logic [SUM_W-1:0]      s1_scaled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_push_q <= 1'b0;
      s1_eval_q <= 1'b0;
    end else begin
      s1_push_q <= push_en;
      s1_eval_q <= eval_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sub_q    <= full;
    s1_price_q  <= price_in;
    s1_elig_q   <= (eff_len >= WLEN_W'(2)) && full;
    s1_newest_q <= newest_q;
    s1_scaled_q <= SUM_W'(eff_len) * SUM_W'(newest_q);
  end

  // ---------------- stage 1: running sum, deviation and product ----------------
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             s1_up;
  logic [SUM_W-1:0] s1_mag;

  always_comb begin
    sum_d = sum_q;
    if (len_we) begin
      sum_d = '0;
    end else if (s1_push_q) begin
      sum_d = sum_q - (s1_sub_q ? SUM_W'(rd_q) : '0) + SUM_W'(s1_price_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign s1_up  = (s1_scaled_q >= sum_q);
  assign s1_mag = s1_up ? (s1_scaled_q - sum_q) : (sum_q - s1_scaled_q);

  logic                  s2_eval_q;
  logic                  s2_go_q, s2_up_q;
  logic [SUM_W-1:0]      s2_mag_q;
  logic [MPR_W-1:0]      s2_prod_q;
  logic [PRICE_BITS-1:0] s2_newest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_eval_q <= 1'b0;
    end else begin
      s2_eval_q <= s1_eval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_go_q     <= s1_elig_q && (sum_q != '0);
    s2_up_q     <= s1_up;
    s2_mag_q    <= s1_mag;
    s2_prod_q   <= MPR_W'(sum_q) * MPR_W'(cfg_thr_q);
    s2_newest_q <= s1_newest_q;
  end

  // ---------------- stage 2: compare and queue the result ----------------
  logic [CMP_W-1:0]               cmp_lhs, cmp_rhs;
  logic                           hit;
  logic [SIG_W-1:0]               res_sig;
  logic [PRICE_BITS+PORT_P_W-1:0] newest_ext;
  logic [PORT_P_W-1:0]            res_price;

  assign cmp_lhs    = {s2_mag_q, {FRAC_W{1'b0}}};
  assign cmp_rhs    = CMP_W'(s2_prod_q);
  assign hit        = s2_go_q && (cmp_lhs > cmp_rhs);
  assign newest_ext = {{PORT_P_W{1'b0}}, s2_newest_q};
  assign res_sig    = !hit ? SIG_HOLD : (s2_up_q ? SIG_BUY : SIG_SELL);
  assign res_price  = hit ? newest_ext[PORT_P_W-1:0] : '0;

  logic [SIG_W-1:0]    q_sig   [OUT_DEPTH];
  logic [PORT_P_W-1:0] q_price [OUT_DEPTH];
  logic [QA_W-1:0]     q_wr_q, q_rd_q;
  logic [QC_W-1:0]     q_cnt_q;
  logic                q_pop;

  assign out_valid_o   = (q_cnt_q != '0);
  assign q_pop         = out_valid_o && !out_stall_i;
  assign signal_o      = q_sig[q_rd_q];
  assign order_price_o = q_price[q_rd_q];

  always_ff @(posedge clk_i) begin
    if (s2_eval_q) begin
      q_sig[q_wr_q]   <= res_sig;
      q_price[q_wr_q] <= res_price;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
      pend_q  <= '0;
    end else begin
      if (s2_eval_q) begin
        q_wr_q <= (q_wr_q == QA_W'(OUT_DEPTH - 1)) ? '0 : q_wr_q + QA_W'(1);
      end
      if (q_pop) begin
        q_rd_q <= (q_rd_q == QA_W'(OUT_DEPTH - 1)) ? '0 : q_rd_q + QA_W'(1);
      end
      q_cnt_q <= q_cnt_q + QC_W'(s2_eval_q) - QC_W'(q_pop);
      // Every accepted evaluate holds a queue slot until its result leaves.
      pend_q  <= pend_q + QC_W'(eval_acc) - QC_W'(q_pop);
    end
  end

  // ---------------- assertions ----------------
  a_pend_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= QC_W'(OUT_DEPTH))
    else $error("outstanding result count exceeds the queue depth");

  a_queue_within_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= pend_q)
    else $error("queued results exceed reserved slots");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_eval_q |-> (q_cnt_q < QC_W'(OUT_DEPTH)) || q_pop)
    else $error("result written into a full queue");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= eff_len)
    else $error("fill count beyond the window length");

  a_wp_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_en && !len_we) |=> (wp_q != $past(wp_q)))
    else $error("write pointer did not advance on a push");

endmodule

`default_nettype wire
